FILE: sv/dllm_pkg.sv
// Shared types and constants for the doubly linked list manager.
// No dependencies; every other file imports this package.
`default_nettype none

package dllm_pkg;

   localparam int OPCODE_W = 3;
   localparam int FIELD_W  = 6;

   localparam logic [OPCODE_W-1:0] OP_ADD_HEAD    = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_ADD_TAIL    = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_ADD_AFTER   = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_ADD_BEFORE  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_UNLINK      = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_REMOVE_HEAD = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_REMOVE_TAIL = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_QUERY       = 3'd7;

   // write enables of the forward and backward link memories
   typedef struct packed {
      logic fwd;
      logic bwd;
   } link_wen_type;

endpackage

`default_nettype wire

FILE: sv/dllm_req_if.sv
// Request channel: valid/ready handshake carrying one list operation.
// Depends on dllm_pkg for the field widths.
`default_nettype none

interface dllm_req_if;
   import dllm_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [FIELD_W-1:0]  target;
   logic [FIELD_W-1:0]  node;

   modport source (output valid, output opcode, output target, output node, input ready);
   modport sink   (input valid, input opcode, input target, input node, output ready);
endinterface

`default_nettype wire

FILE: sv/dllm_rsp_if.sv
// Response channel: valid/ready handshake carrying one operation result.
// Depends on dllm_pkg for the field widths.
`default_nettype none

interface dllm_rsp_if;
   import dllm_pkg::*;

   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] result_node;
   logic               list_was_empty;
   logic               error;
   logic               is_linked;

   modport source (output valid, output result_node, output list_was_empty,
                   output error, output is_linked, input ready);
   modport sink   (input valid, input result_node, input list_was_empty,
                   input error, input is_linked, output ready);
endinterface

`default_nettype wire

FILE: sv/dllm_links.sv
// Forward and backward link memories with registered reads, plus the
// post-reset sweep that makes every node point at itself. Uses dllm_pkg.
`default_nettype none

module dllm_links #(
   parameter int NODES = 64,
   localparam int IW = $clog2(NODES)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [IW-1:0]         f_raddr0,
   input  wire logic [IW-1:0]         f_raddr1,
   input  wire logic [IW-1:0]         b_raddr,
   output logic      [IW-1:0]         f_rdata0,
   output logic      [IW-1:0]         f_rdata1,
   output logic      [IW-1:0]         b_rdata,
   input  wire dllm_pkg::link_wen_type wen,
   input  wire logic [IW-1:0]         f_waddr,
   input  wire logic [IW-1:0]         f_wdata,
   input  wire logic [IW-1:0]         b_waddr,
   input  wire logic [IW-1:0]         b_wdata,
   output logic                       links_ready
);
   import dllm_pkg::*;

   logic [IW-1:0] fwd_mem [NODES];
   logic [IW-1:0] bwd_mem [NODES];

   logic [IW-1:0] clr_ff, clr_in;
   logic          clr_busy_ff, clr_busy_in;

   always_comb begin
      clr_in      = clr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == IW'(NODES - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_ff      <= clr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   // sweep has the write port until every entry is self-linked
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         fwd_mem[clr_ff] <= clr_ff;
         bwd_mem[clr_ff] <= clr_ff;
      end else begin
         if (wen.fwd) begin
            fwd_mem[f_waddr] <= f_wdata;
         end
         if (wen.bwd) begin
            bwd_mem[b_waddr] <= b_wdata;
         end
      end
      f_rdata0 <= fwd_mem[f_raddr0];
      f_rdata1 <= fwd_mem[f_raddr1];
      b_rdata  <= bwd_mem[b_raddr];
   end

   assign links_ready = !clr_busy_ff;

endmodule

`default_nettype wire

FILE: sv/dllm_ctrl.sv
// Operation sequencer: fetches links, applies the ordered link writes and
// holds the result in an output register. Uses dllm_pkg and both channels.
`default_nettype none

module dllm_ctrl #(
   parameter int NODES = 64,
   localparam int IW = $clog2(NODES)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   dllm_req_if.sink                    req_ch,
   dllm_rsp_if.source                  rsp_ch,
   input  wire logic                   links_ready,
   output logic      [IW-1:0]          f_raddr0,
   output logic      [IW-1:0]          f_raddr1,
   output logic      [IW-1:0]          b_raddr,
   input  wire logic [IW-1:0]          f_rdata0,
   input  wire logic [IW-1:0]          f_rdata1,
   input  wire logic [IW-1:0]          b_rdata,
   output dllm_pkg::link_wen_type      wen,
   output logic      [IW-1:0]          f_waddr,
   output logic      [IW-1:0]          f_wdata,
   output logic      [IW-1:0]          b_waddr,
   output logic      [IW-1:0]          b_wdata
);
   import dllm_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EVAL = 3'd1;
   localparam logic [2:0] S_LINK = 3'd2;
   localparam logic [2:0] S_WR1  = 3'd3;
   localparam logic [2:0] S_WR2  = 3'd4;
   localparam logic [2:0] S_RESP = 3'd5;

   // fold a field into the pool by subtracting shifted copies of NODES
   function automatic logic [IW-1:0] to_idx(input logic [FIELD_W-1:0] v);
      logic [31:0] r;
      r = 32'(v);
      for (int k = FIELD_W - 1; k >= 0; k--) begin
         if (r >= (32'(NODES) << k)) begin
            r = r - (32'(NODES) << k);
         end
      end
      return r[IW-1:0];
   endfunction

   function automatic logic [FIELD_W-1:0] to_field(input logic [IW-1:0] v);
      logic [IW+FIELD_W-1:0] w;
      w = (IW + FIELD_W)'(v);
      return w[FIELD_W-1:0];
   endfunction

   logic [2:0]          state_ff, state_in;
   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [IW-1:0]       tgt_ff, tgt_in;
   logic [IW-1:0]       nd_ff, nd_in;
   logic [IW-1:0]       a_ff, a_in;
   logic [IW-1:0]       b_ff, b_in;

   logic [IW-1:0]       pend_node_ff, pend_node_in;
   logic                pend_empty_ff, pend_empty_in;
   logic                pend_err_ff, pend_err_in;
   logic                pend_lnk_ff, pend_lnk_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0]  rsp_node_ff, rsp_node_in;
   logic                rsp_empty_ff, rsp_empty_in;
   logic                rsp_err_ff, rsp_err_in;
   logic                rsp_lnk_ff, rsp_lnk_in;

   logic                accept;
   logic                slot_free;
   logic [IW-1:0]       req_tgt, req_nd;
   logic                req_remove, op_remove;

   logic                fin;
   logic [IW-1:0]       fin_node;
   logic                fin_empty, fin_err, fin_lnk;

   assign req_ch.ready = (state_ff == S_IDLE) && links_ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign req_tgt      = to_idx(req_ch.target);
   assign req_nd       = to_idx(req_ch.node);
   assign req_remove   = (req_ch.opcode == OP_REMOVE_HEAD) ||
                         (req_ch.opcode == OP_REMOVE_TAIL);
   assign op_remove    = (op_ff == OP_REMOVE_HEAD) || (op_ff == OP_REMOVE_TAIL);

   // first fetch straight off the request beat; second fetch follows a link
   always_comb begin
      f_raddr0 = req_remove ? req_tgt : req_nd;
      f_raddr1 = req_tgt;
      b_raddr  = (req_ch.opcode == OP_UNLINK) ? req_nd : req_tgt;
      if (state_ff == S_EVAL) begin
         f_raddr0 = f_rdata0;
         f_raddr1 = tgt_ff;
         b_raddr  = b_rdata;
      end
   end

   // two ordered writes per memory; order within a memory follows the list rules
   always_comb begin
      wen     = '0;
      f_waddr = nd_ff;
      f_wdata = nd_ff;
      b_waddr = nd_ff;
      b_wdata = nd_ff;
      if (state_ff == S_WR1 || state_ff == S_WR2) begin
         wen.fwd = 1'b1;
         wen.bwd = 1'b1;
      end
      if (state_ff == S_WR1) begin
         unique case (op_ff)
            OP_ADD_HEAD, OP_ADD_AFTER: begin
               f_waddr = nd_ff;  f_wdata = a_ff;
               b_waddr = nd_ff;  b_wdata = tgt_ff;
            end
            OP_ADD_TAIL, OP_ADD_BEFORE: begin
               f_waddr = nd_ff;  f_wdata = tgt_ff;
               b_waddr = nd_ff;  b_wdata = a_ff;
            end
            OP_UNLINK: begin
               f_waddr = a_ff;   f_wdata = b_ff;
               b_waddr = b_ff;   b_wdata = a_ff;
            end
            OP_REMOVE_HEAD: begin
               f_waddr = tgt_ff; f_wdata = b_ff;
               b_waddr = b_ff;   b_wdata = tgt_ff;
            end
            OP_REMOVE_TAIL: begin
               f_waddr = b_ff;   f_wdata = tgt_ff;
               b_waddr = tgt_ff; b_wdata = b_ff;
            end
            OP_QUERY: begin
               wen = '0;
            end
         endcase
      end else if (state_ff == S_WR2) begin
         unique case (op_ff)
            OP_ADD_HEAD, OP_ADD_AFTER: begin
               f_waddr = tgt_ff; f_wdata = nd_ff;
               b_waddr = a_ff;   b_wdata = nd_ff;
            end
            OP_ADD_TAIL, OP_ADD_BEFORE: begin
               f_waddr = a_ff;   f_wdata = nd_ff;
               b_waddr = tgt_ff; b_wdata = nd_ff;
            end
            OP_UNLINK: begin
               f_waddr = nd_ff;  f_wdata = nd_ff;
               b_waddr = nd_ff;  b_wdata = nd_ff;
            end
            OP_REMOVE_HEAD, OP_REMOVE_TAIL: begin
               f_waddr = a_ff;   f_wdata = a_ff;
               b_waddr = a_ff;   b_wdata = a_ff;
            end
            OP_QUERY: begin
               wen = '0;
            end
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      tgt_in        = tgt_ff;
      nd_in         = nd_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      pend_node_in  = pend_node_ff;
      pend_empty_in = pend_empty_ff;
      pend_err_in   = pend_err_ff;
      pend_lnk_in   = pend_lnk_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_node_in   = rsp_node_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_err_in    = rsp_err_ff;
      rsp_lnk_in    = rsp_lnk_ff;
      fin           = 1'b0;
      fin_node      = nd_ff;
      fin_empty     = 1'b0;
      fin_err       = 1'b0;
      fin_lnk       = 1'b0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_ch.opcode;
               tgt_in   = req_tgt;
               nd_in    = req_nd;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            unique case (op_ff)
               OP_ADD_HEAD, OP_ADD_AFTER, OP_ADD_TAIL, OP_ADD_BEFORE: begin
                  if (f_rdata0 != nd_ff) begin
                     fin     = 1'b1;
                     fin_err = 1'b1;
                  end else begin
                     a_in     = (op_ff == OP_ADD_HEAD || op_ff == OP_ADD_AFTER) ?
                                f_rdata1 : b_rdata;
                     state_in = S_WR1;
                  end
               end
               OP_UNLINK: begin
                  a_in     = b_rdata;
                  b_in     = f_rdata0;
                  state_in = S_WR1;
               end
               OP_REMOVE_HEAD, OP_REMOVE_TAIL: begin
                  if (f_rdata0 == tgt_ff) begin
                     fin       = 1'b1;
                     fin_node  = tgt_ff;
                     fin_empty = 1'b1;
                  end else begin
                     a_in     = (op_ff == OP_REMOVE_HEAD) ? f_rdata0 : b_rdata;
                     state_in = S_LINK;
                  end
               end
               OP_QUERY: begin
                  fin     = 1'b1;
                  fin_lnk = (f_rdata0 != nd_ff);
               end
            endcase
         end
         S_LINK: begin
            b_in     = (op_ff == OP_REMOVE_HEAD) ? f_rdata0 : b_rdata;
            state_in = S_WR1;
         end
         S_WR1: begin
            state_in = S_WR2;
         end
         S_WR2: begin
            fin      = 1'b1;
            fin_node = op_remove ? a_ff : nd_ff;
         end
         S_RESP: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_node_in  = to_field(pend_node_ff);
               rsp_empty_in = pend_empty_ff;
               rsp_err_in   = pend_err_ff;
               rsp_lnk_in   = pend_lnk_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // load the output register now if it is free, else park the result
      if (fin) begin
         if (slot_free) begin
            rsp_valid_in = 1'b1;
            rsp_node_in  = to_field(fin_node);
            rsp_empty_in = fin_empty;
            rsp_err_in   = fin_err;
            rsp_lnk_in   = fin_lnk;
            state_in     = S_IDLE;
         end else begin
            pend_node_in  = fin_node;
            pend_empty_in = fin_empty;
            pend_err_in   = fin_err;
            pend_lnk_in   = fin_lnk;
            state_in      = S_RESP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      tgt_ff        <= tgt_in;
      nd_ff         <= nd_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      pend_node_ff  <= pend_node_in;
      pend_empty_ff <= pend_empty_in;
      pend_err_ff   <= pend_err_in;
      pend_lnk_ff   <= pend_lnk_in;
      rsp_node_ff   <= rsp_node_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_err_ff    <= rsp_err_in;
      rsp_lnk_ff    <= rsp_lnk_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.result_node    = rsp_node_ff;
   assign rsp_ch.list_was_empty = rsp_empty_ff;
   assign rsp_ch.error          = rsp_err_ff;
   assign rsp_ch.is_linked      = rsp_lnk_ff;

endmodule

`default_nettype wire

FILE: sv/doubly_linked_list_manager.sv
// Channel   Dir  Beat contents
// req_ch    in   opcode, target, node
// rsp_ch    out  result_node, list_was_empty, error, is_linked
//
// One operation at a time. Each operation passes a link read (S_EVAL); query, an add naming a
// linked node and a removal from an empty list finish there. Add and unlink then take the
// two write states S_WR1 and S_WR2; head/tail removal first takes a dependent read (S_LINK).
// After reset, req_ch.ready stays low while a sweep self-links every node.
// A stalled rsp_ch holds the finished result; the next beat is still taken, and a second
// result waits in the sequencer until the output register frees.
// Top level of the doubly linked list manager; uses dllm_pkg, both channel
// interfaces, dllm_links and dllm_ctrl.
`default_nettype none

module doubly_linked_list_manager #(
   parameter int NODES = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   dllm_req_if.sink   req_ch,
   dllm_rsp_if.source rsp_ch
);
   import dllm_pkg::*;

   localparam int IW = $clog2(NODES);

   logic [IW-1:0] f_raddr0, f_raddr1, b_raddr;
   logic [IW-1:0] f_rdata0, f_rdata1, b_rdata;
   logic [IW-1:0] f_waddr, f_wdata, b_waddr, b_wdata;
   link_wen_type  wen;
   logic          links_ready;

   dllm_links #(.NODES(NODES)) u_links (
      .clock       (clock),
      .reset       (reset),
      .f_raddr0    (f_raddr0),
      .f_raddr1    (f_raddr1),
      .b_raddr     (b_raddr),
      .f_rdata0    (f_rdata0),
      .f_rdata1    (f_rdata1),
      .b_rdata     (b_rdata),
      .wen         (wen),
      .f_waddr     (f_waddr),
      .f_wdata     (f_wdata),
      .b_waddr     (b_waddr),
      .b_wdata     (b_wdata),
      .links_ready (links_ready)
   );

   dllm_ctrl #(.NODES(NODES)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .links_ready (links_ready),
      .f_raddr0    (f_raddr0),
      .f_raddr1    (f_raddr1),
      .b_raddr     (b_raddr),
      .f_rdata0    (f_rdata0),
      .f_rdata1    (f_rdata1),
      .b_rdata     (b_rdata),
      .wen         (wen),
      .f_waddr     (f_waddr),
      .f_wdata     (f_wdata),
      .b_waddr     (b_waddr),
      .b_wdata     (b_wdata)
   );

endmodule

`default_nettype wire

FILE: bench/dllm_list_checker.sv
// Result checker for the doubly linked list manager: keeps its own copy of the
// forward and backward links and checks every response beat against it.
// Depends on dllm_pkg and the dllm_req_if / dllm_rsp_if channel interfaces.
`timescale 1ns / 100ps

module dllm_list_checker #(
   parameter int NODES = 64
) (
   input  logic  clock,
   input  logic  reset,
   dllm_req_if   req_ch,
   dllm_rsp_if   rsp_ch,
   output int    fail_count,
   output int    req_beats,
   output int    rsp_beats,
   output int    pending
);
   import dllm_pkg::*;

   typedef struct {
      logic [OPCODE_W-1:0] opcode;
      logic [FIELD_W-1:0]  target;
      logic [FIELD_W-1:0]  node;
      logic [FIELD_W-1:0]  result_node;
      logic                list_was_empty;
      logic                error;
      logic                is_linked;
   } list_op_result_type;

   int                 next_node [NODES];
   int                 prev_node [NODES];
   list_op_result_type pending_results [$];

   // Apply one operation to the link copy and return the response it gives.
   // Link writes go in order, so aliased operands see earlier writes.
   function automatic list_op_result_type apply_list_op(input logic [OPCODE_W-1:0] op,
                                                         input logic [FIELD_W-1:0]  tgt,
                                                         input logic [FIELD_W-1:0]  nd);
      list_op_result_type r;
      int                 t;
      int                 n;
      int                 m;
      t = int'(tgt) % NODES;
      n = int'(nd) % NODES;
      r.opcode         = op;
      r.target         = tgt;
      r.node           = nd;
      r.result_node    = n[FIELD_W-1:0];
      r.list_was_empty = 1'b0;
      r.error          = 1'b0;
      r.is_linked      = 1'b0;
      case (op)
         OP_ADD_HEAD, OP_ADD_AFTER, OP_ADD_TAIL, OP_ADD_BEFORE: begin
            if (next_node[n] != n) begin
               r.error = 1'b1;
            end else if (op == OP_ADD_HEAD || op == OP_ADD_AFTER) begin
               prev_node[n]            = t;
               next_node[n]            = next_node[t];
               prev_node[next_node[t]] = n;
               next_node[t]            = n;
            end else begin
               next_node[n]            = t;
               prev_node[n]            = prev_node[t];
               next_node[prev_node[t]] = n;
               prev_node[t]            = n;
            end
         end
         OP_UNLINK: begin
            next_node[prev_node[n]] = next_node[n];
            prev_node[next_node[n]] = prev_node[n];
            next_node[n]            = n;
            prev_node[n]            = n;
         end
         OP_REMOVE_HEAD, OP_REMOVE_TAIL: begin
            if (next_node[t] == t) begin
               r.list_was_empty = 1'b1;
               r.result_node    = t[FIELD_W-1:0];
            end else if (op == OP_REMOVE_HEAD) begin
               m                       = next_node[t];
               prev_node[next_node[m]] = t;
               next_node[t]            = next_node[m];
               next_node[m]            = m;
               prev_node[m]            = m;
               r.result_node           = m[FIELD_W-1:0];
            end else begin
               m                       = prev_node[t];
               next_node[prev_node[m]] = t;
               prev_node[t]            = prev_node[m];
               next_node[m]            = m;
               prev_node[m]            = m;
               r.result_node           = m[FIELD_W-1:0];
            end
         end
         OP_QUERY: begin
            r.is_linked = (next_node[n] != n);
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string field, input int want, input int got,
                              input list_op_result_type op);
      if (want != got)
         report_mismatch($sformatf("%s expected %0d got %0d (op %0d target %0d node %0d)",
                                   field, want, got, op.opcode, op.target, op.node));
   endtask

   always @(posedge clock) begin : monitor
      list_op_result_type want;
      if (reset) begin
         for (int i = 0; i < NODES; i++) begin
            next_node[i] = i;
            prev_node[i] = i;
         end
         pending_results.delete();
         fail_count = 0;
         req_beats  = 0;
         rsp_beats  = 0;
      end else begin
         // take the response first: a request in the same cycle cannot have produced it
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_beats++;
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("response beat with nothing outstanding, node %0d",
                                         rsp_ch.result_node));
            end else begin
               want = pending_results.pop_front();
               check_field("result_node", int'(want.result_node),
                           int'(rsp_ch.result_node), want);
               check_field("list_was_empty", int'(want.list_was_empty),
                           int'(rsp_ch.list_was_empty), want);
               check_field("error", int'(want.error), int'(rsp_ch.error), want);
               check_field("is_linked", int'(want.is_linked), int'(rsp_ch.is_linked), want);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            req_beats++;
            pending_results.push_back(apply_list_op(req_ch.opcode, req_ch.target, req_ch.node));
         end
      end
      pending = pending_results.size();
   end

endmodule

FILE: bench/tb_doubly_linked_list_manager.sv
// Top of the doubly linked list manager testbench: clock, reset, request and
// response driving, and the verdict. Uses dllm_pkg, both channel interfaces,
// the block itself and dllm_list_checker.
`timescale 1ns / 100ps

module tb_doubly_linked_list_manager;
   import dllm_pkg::*;

   localparam int NODES = 64;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dllm_req_if req_ch ();
   dllm_rsp_if rsp_ch ();

   int fail_count;
   int req_beats;
   int rsp_beats;
   int pending;

   int ops_sent = 0;
   int op_count [8];
   bit sender_idles = 1'b1;
   bit sink_idles   = 1'b1;
   bit hold_sink    = 1'b0;

   doubly_linked_list_manager #(.NODES(NODES)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   dllm_list_checker #(.NODES(NODES)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .fail_count (fail_count),
      .req_beats  (req_beats),
      .rsp_beats  (rsp_beats),
      .pending    (pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #400000;
      $display("Timeout: run did not drain");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Response side: short random stalls, or one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_sink) begin
            rsp_ch.ready <= 1'b0;
            repeat (80) @(posedge clock);
            hold_sink = 1'b0;
         end else if (sink_idles && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   // Mostly a small pool so lists grow, collide and empty again.
   function automatic logic [FIELD_W-1:0] pick_node();
      if ($urandom_range(0, 4) == 0)
         return FIELD_W'($urandom_range(0, 63));
      return FIELD_W'($urandom_range(0, 15));
   endfunction

   task automatic issue_op(input logic [OPCODE_W-1:0] op, input logic [FIELD_W-1:0] tgt,
                           input logic [FIELD_W-1:0] nd);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.opcode <= op;
      req_ch.target <= tgt;
      req_ch.node   <= nd;
      do @(posedge clock); while (!req_ch.ready);
      op_count[op]++;
      ops_sent++;
   endtask

   task automatic run_random_ops(input int count);
      logic [OPCODE_W-1:0] op;
      logic [FIELD_W-1:0]  tgt;
      logic [FIELD_W-1:0]  nd;
      int                  roll;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < 14)      op = OP_ADD_HEAD;
         else if (roll < 28) op = OP_ADD_TAIL;
         else if (roll < 38) op = OP_ADD_AFTER;
         else if (roll < 48) op = OP_ADD_BEFORE;
         else if (roll < 60) op = OP_UNLINK;
         else if (roll < 72) op = OP_REMOVE_HEAD;
         else if (roll < 84) op = OP_REMOVE_TAIL;
         else                op = OP_QUERY;
         nd = pick_node();
         if (op == OP_ADD_AFTER || op == OP_ADD_BEFORE)
            tgt = pick_node();
         else if (op == OP_UNLINK || op == OP_QUERY)
            tgt = FIELD_W'($urandom_range(0, 63));
         else
            tgt = ($urandom_range(0, 9) < 7) ? FIELD_W'($urandom_range(0, 3)) : pick_node();
         issue_op(op, tgt, nd);
      end
      req_ch.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      wait (req_beats == ops_sent && pending == 0);
   endtask

   initial begin
      req_ch.valid  = 1'b0;
      req_ch.opcode = OP_QUERY;
      req_ch.target = '0;
      req_ch.node   = '0;
      rsp_ch.ready  = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty lists, every add form, duplicate adds, unlinks, queries, removals, aliasing
      issue_op(OP_QUERY,       6'd0,  6'd0);
      issue_op(OP_REMOVE_HEAD, 6'd63, 6'd0);
      issue_op(OP_REMOVE_TAIL, 6'd0,  6'd63);
      issue_op(OP_ADD_HEAD,    6'd0,  6'd1);
      issue_op(OP_ADD_TAIL,    6'd0,  6'd2);
      issue_op(OP_ADD_AFTER,   6'd1,  6'd3);
      issue_op(OP_ADD_BEFORE,  6'd2,  6'd4);
      issue_op(OP_ADD_HEAD,    6'd0,  6'd1);
      issue_op(OP_ADD_TAIL,    6'd63, 6'd0);
      issue_op(OP_QUERY,       6'd63, 6'd1);
      issue_op(OP_QUERY,       6'd0,  6'd0);
      issue_op(OP_REMOVE_HEAD, 6'd0,  6'd0);
      issue_op(OP_REMOVE_TAIL, 6'd0,  6'd0);
      issue_op(OP_UNLINK,      6'd0,  6'd3);
      issue_op(OP_UNLINK,      6'd0,  6'd3);
      issue_op(OP_ADD_HEAD,    6'd63, 6'd63);
      issue_op(OP_ADD_AFTER,   6'd40, 6'd41);
      issue_op(OP_ADD_BEFORE,  6'd62, 6'd62);
      issue_op(OP_ADD_TAIL,    6'd0,  6'd63);
      issue_op(OP_UNLINK,      6'd63, 6'd0);
      issue_op(OP_QUERY,       6'd63, 6'd4);
      issue_op(OP_REMOVE_HEAD, 6'd63, 6'd63);
      issue_op(OP_QUERY,       6'd63, 6'd63);
      req_ch.valid <= 1'b0;
      wait_drained();

      run_random_ops(150);
      // stall the response side and keep offering until the input backs up
      hold_sink = 1'b1;
      run_random_ops(16);
      run_random_ops(150);
      wait_drained();

      run_random_ops(230);
      sender_idles = 1'b0;
      sink_idles   = 1'b0;
      run_random_ops(150);

      wait_drained();
      repeat (20) @(posedge clock);
      $display("Covered %0d operations: add head/tail/after/before %0d/%0d/%0d/%0d,",
               ops_sent, op_count[OP_ADD_HEAD], op_count[OP_ADD_TAIL],
               op_count[OP_ADD_AFTER], op_count[OP_ADD_BEFORE]);
      $display("unlink %0d, remove head/tail %0d/%0d, query %0d; %0d responses checked.",
               op_count[OP_UNLINK], op_count[OP_REMOVE_HEAD], op_count[OP_REMOVE_TAIL],
               op_count[OP_QUERY], rsp_beats);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: filelist.f
sv/dllm_pkg.sv
sv/dllm_req_if.sv
sv/dllm_rsp_if.sv
sv/dllm_links.sv
sv/dllm_ctrl.sv
sv/doubly_linked_list_manager.sv
bench/dllm_list_checker.sv
bench/tb_doubly_linked_list_manager.sv
